// File: hw/rtl/bsws_pkg.sv
// ----------------------------------------------------------------------------
// bsws_pkg: shared types and constants of the bounded stack with search
// Request codes, the decoded operation type, the command that travels from
// the front queue to the execution side, and the back-end state type.
// ----------------------------------------------------------------------------
package bsws_pkg;

   localparam int DATA_W        = 32;
   localparam int REQ_W         = 3;
   localparam int DEFAULT_DEPTH = 64;
   localparam int Q_DEPTH       = 2;
   localparam int CSR_ADDR_W    = 3;
   localparam int CSR_DATA_W    = 32;
   localparam int CAP_W         = 7;

   localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

   localparam logic [REQ_W-1:0] REQ_PUSH   = 3'd0;
   localparam logic [REQ_W-1:0] REQ_POP    = 3'd1;
   localparam logic [REQ_W-1:0] REQ_PEEK   = 3'd2;
   localparam logic [REQ_W-1:0] REQ_CLEAR  = 3'd3;
   localparam logic [REQ_W-1:0] REQ_SEARCH = 3'd4;

   localparam logic CSR_IDX_CAPACITY = 1'b0;

   typedef enum logic [2:0] {
      OP_PUSH,
      OP_POP,
      OP_PEEK,
      OP_CLEAR,
      OP_SEARCH,
      OP_BAD
   } op_type;

   typedef struct packed {
      op_type            op;
      logic [DATA_W-1:0] data;
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_SCAN
   } back_state_type;

endpackage

// File: hw/rtl/bsws_ram.sv
// ----------------------------------------------------------------------------
// bsws_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered and holds
// until the next read enable.
// ----------------------------------------------------------------------------
module bsws_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/bsws_csr.sv
// ----------------------------------------------------------------------------
// bsws_csr: configuration register block
// Holds the capacity register behind the APB-style port and derives the
// effective capacity, clamped to 1..DEPTH.
// ----------------------------------------------------------------------------
module bsws_csr #(
   parameter int DEPTH = bsws_pkg::DEFAULT_DEPTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [bsws_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [bsws_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [bsws_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready,
   output logic [$clog2(DEPTH+1)-1:0]          cap_eff
);

   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [bsws_pkg::CAP_W-1:0] cap_ff;
   logic [bsws_pkg::CAP_W-1:0] cap_in;
   logic                       wr_cap;

   assign pready = 1'b1;
   assign wr_cap = psel && penable && pwrite && (paddr[2] == bsws_pkg::CSR_IDX_CAPACITY);

   always_comb begin
      cap_in = cap_ff;
      if (wr_cap) begin
         cap_in = pwdata[bsws_pkg::CAP_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= bsws_pkg::CAP_RESET;
      end else begin
         cap_ff <= cap_in;
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[2] == bsws_pkg::CSR_IDX_CAPACITY) begin
         prdata = bsws_pkg::CSR_DATA_W'(cap_ff);
      end
   end

   always_comb begin
      cap_eff = CNT_W'(DEPTH);
      if (cap_ff == '0) begin
         cap_eff = CNT_W'(1);
      end else if (int'(cap_ff) < DEPTH) begin
         cap_eff = CNT_W'(cap_ff);
      end
   end

endmodule

// File: hw/rtl/bsws_front.sv
// ----------------------------------------------------------------------------
// bsws_front: request front end
// Decodes the request code and buffers commands in a two-entry queue that
// decouples the request channel from the execution side.
// ----------------------------------------------------------------------------
module bsws_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [bsws_pkg::REQ_W-1:0]      req_type,
   input  logic [bsws_pkg::DATA_W-1:0]     req_data,
   output logic                            cmd_valid,
   input  logic                            cmd_ready,
   output bsws_pkg::cmd_type               cmd
);

   localparam int PTR_W = $clog2(bsws_pkg::Q_DEPTH);
   localparam int QCNT_W = $clog2(bsws_pkg::Q_DEPTH + 1);

   bsws_pkg::cmd_type q_ff [bsws_pkg::Q_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] fill_ff, fill_in;
   bsws_pkg::op_type  op_dec;
   logic              push, pop;

   always_comb begin
      unique case (req_type)
         bsws_pkg::REQ_PUSH:   op_dec = bsws_pkg::OP_PUSH;
         bsws_pkg::REQ_POP:    op_dec = bsws_pkg::OP_POP;
         bsws_pkg::REQ_PEEK:   op_dec = bsws_pkg::OP_PEEK;
         bsws_pkg::REQ_CLEAR:  op_dec = bsws_pkg::OP_CLEAR;
         bsws_pkg::REQ_SEARCH: op_dec = bsws_pkg::OP_SEARCH;
         default:              op_dec = bsws_pkg::OP_BAD;
      endcase
   end

   assign req_ready = (fill_ff != QCNT_W'(bsws_pkg::Q_DEPTH));
   assign cmd_valid = (fill_ff != '0);
   assign cmd       = q_ff[rd_ptr_ff];
   assign push      = req_valid && req_ready;
   assign pop       = cmd_valid && cmd_ready;

   // queue depth is a power of two, so the pointers wrap on their own
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         fill_in = fill_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff].op   <= op_dec;
         q_ff[wr_ptr_ff].data <= req_data;
      end
   end

endmodule

// File: hw/rtl/bsws_back.sv
// ----------------------------------------------------------------------------
// bsws_back: stack execution engine
// Owns the entry RAM and the entry count, carries out one command at a time
// and holds the result in an output register until it is taken.
// ----------------------------------------------------------------------------
module bsws_back #(
   parameter int DEPTH = bsws_pkg::DEFAULT_DEPTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            cmd_valid,
   output logic                            cmd_ready,
   input  bsws_pkg::cmd_type               cmd,
   input  logic [$clog2(DEPTH+1)-1:0]      cap_eff,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_ok,
   output logic [bsws_pkg::DATA_W-1:0]     rsp_value,
   output logic [$clog2(DEPTH+1)-1:0]      rsp_position,
   output logic [$clog2(DEPTH+1)-1:0]      rsp_count,
   output logic                            rsp_is_empty,
   output logic                            rsp_is_full
);

   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int ADDR_W = $clog2(DEPTH);

   bsws_pkg::back_state_type state_ff, state_in;
   logic [CNT_W-1:0]            count_ff, count_in;
   logic [CNT_W-1:0]            scan_ff, scan_in;
   logic [bsws_pkg::DATA_W-1:0] key_ff, key_in;

   logic                        wr_en, rd_en;
   logic [ADDR_W-1:0]           wr_addr, rd_addr;
   logic [bsws_pkg::DATA_W-1:0] rd_data;
   logic [CNT_W-1:0]            count_m1, scan_m2;

   logic                        out_free, load;
   logic                        res_ok;
   logic [bsws_pkg::DATA_W-1:0] res_value;
   logic [CNT_W-1:0]            res_pos;
   logic                        hit;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        rsp_ok_ff;
   logic [bsws_pkg::DATA_W-1:0] rsp_value_ff;
   logic [CNT_W-1:0]            rsp_position_ff, rsp_count_ff;
   logic                        rsp_is_empty_ff, rsp_is_full_ff;

   bsws_ram #(
      .WIDTH (bsws_pkg::DATA_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (cmd.data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign count_m1 = count_ff - CNT_W'(1);
   assign scan_m2  = scan_ff - CNT_W'(2);
   assign wr_addr  = count_ff[ADDR_W-1:0];
   assign hit      = (rd_data == key_ff);

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      scan_in   = scan_ff;
      key_in    = key_ff;
      cmd_ready = 1'b0;
      wr_en     = 1'b0;
      rd_en     = 1'b0;
      rd_addr   = count_m1[ADDR_W-1:0];
      load      = 1'b0;
      res_ok    = 1'b0;
      res_value = '0;
      res_pos   = '0;
      unique case (state_ff)
         bsws_pkg::ST_IDLE: begin
            if (cmd_valid) begin
               case (cmd.op) inside
                  bsws_pkg::OP_PUSH: begin
                     if (out_free) begin
                        cmd_ready = 1'b1;
                        load      = 1'b1;
                        if (count_ff < cap_eff) begin
                           wr_en    = 1'b1;
                           count_in = count_ff + CNT_W'(1);
                           res_ok   = 1'b1;
                        end
                     end
                  end
                  bsws_pkg::OP_POP, bsws_pkg::OP_PEEK: begin
                     if (count_ff == '0) begin
                        if (out_free) begin
                           cmd_ready = 1'b1;
                           load      = 1'b1;
                        end
                     end else begin
                        cmd_ready = 1'b1;
                        rd_en     = 1'b1;
                        state_in  = bsws_pkg::ST_READ;
                        if (cmd.op == bsws_pkg::OP_POP) begin
                           count_in = count_m1;
                        end
                     end
                  end
                  bsws_pkg::OP_CLEAR: begin
                     if (out_free) begin
                        cmd_ready = 1'b1;
                        load      = 1'b1;
                        count_in  = '0;
                        res_ok    = 1'b1;
                     end
                  end
                  bsws_pkg::OP_SEARCH: begin
                     if (count_ff == '0) begin
                        if (out_free) begin
                           cmd_ready = 1'b1;
                           load      = 1'b1;
                           res_ok    = 1'b1;
                        end
                     end else begin
                        cmd_ready = 1'b1;
                        rd_en     = 1'b1;
                        scan_in   = count_ff;
                        key_in    = cmd.data;
                        state_in  = bsws_pkg::ST_SCAN;
                     end
                  end
                  default: begin
                     if (out_free) begin
                        cmd_ready = 1'b1;
                        load      = 1'b1;
                     end
                  end
               endcase
            end
         end
         bsws_pkg::ST_READ: begin
            if (out_free) begin
               load      = 1'b1;
               res_ok    = 1'b1;
               res_value = rd_data;
               state_in  = bsws_pkg::ST_IDLE;
            end
         end
         bsws_pkg::ST_SCAN: begin
            // rd_data holds entry scan_ff (1-based); walk downward
            if (hit || (scan_ff == CNT_W'(1))) begin
               if (out_free) begin
                  load     = 1'b1;
                  res_ok   = 1'b1;
                  res_pos  = hit ? scan_ff : '0;
                  state_in = bsws_pkg::ST_IDLE;
               end
            end else begin
               rd_en   = 1'b1;
               rd_addr = scan_m2[ADDR_W-1:0];
               scan_in = scan_ff - CNT_W'(1);
            end
         end
         default: begin
            state_in = bsws_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bsws_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff <= scan_in;
      key_ff  <= key_in;
      if (load) begin
         rsp_ok_ff       <= res_ok;
         rsp_value_ff    <= res_value;
         rsp_position_ff <= res_pos;
         rsp_count_ff    <= count_in;
         rsp_is_empty_ff <= (count_in == '0);
         rsp_is_full_ff  <= (count_in >= cap_eff);
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_ok       = rsp_ok_ff;
   assign rsp_value    = rsp_value_ff;
   assign rsp_position = rsp_position_ff;
   assign rsp_count    = rsp_count_ff;
   assign rsp_is_empty = rsp_is_empty_ff;
   assign rsp_is_full  = rsp_is_full_ff;

endmodule

// File: hw/rtl/bounded_stack_with_search_top.sv
// ----------------------------------------------------------------------------
// bounded_stack_with_search_top: LIFO stack of 32-bit words with search
// Requests (push, pop, peek, clear, search) enter on the req_ valid/ready
// channel; each transfer yields exactly one result transfer on rsp_.
// A two-entry command queue sits between the request channel and the
// execution engine, and results sit in an output register, so requests are
// still taken while a result waits for rsp_ready.
// Push, clear and unknown codes pass through the command queue and the
// output register; pop and peek also take one registered RAM read, and a
// search compares entries from the top down, one entry per cycle through
// the single RAM read port, and then waits while the result is held.
// The engine takes a new command only once it has finished the last one.
// Reset empties the stack and sets capacity to 64, clamped to DEPTH; entry
// contents are not cleared. When rsp_ready is low, the engine holds its
// result and the queue fills, after which req_ready drops.
// Capacity is written through the APB-style port at address 0; the user must
// write it only while idle, which the block itself does not enforce.
module bounded_stack_with_search_top #(
   parameter int DEPTH = bsws_pkg::DEFAULT_DEPTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [bsws_pkg::REQ_W-1:0]      req_type,
   input  logic [bsws_pkg::DATA_W-1:0]     req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_ok,
   output logic [bsws_pkg::DATA_W-1:0]     rsp_value,
   output logic [$clog2(DEPTH+1)-1:0]      rsp_position,
   output logic [$clog2(DEPTH+1)-1:0]      rsp_count,
   output logic                            rsp_is_empty,
   output logic                            rsp_is_full,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [bsws_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [bsws_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [bsws_pkg::CSR_DATA_W-1:0] prdata,
   output logic                            pready
);

   localparam int CNT_W = $clog2(DEPTH + 1);

   logic              cmd_valid, cmd_ready;
   bsws_pkg::cmd_type cmd;
   logic [CNT_W-1:0]  cap_eff;

   bsws_csr #(
      .DEPTH (DEPTH)
   ) u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cap_eff (cap_eff)
   );

   bsws_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_type  (req_type),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd       (cmd)
   );

   bsws_back #(
      .DEPTH (DEPTH)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .cmd_valid    (cmd_valid),
      .cmd_ready    (cmd_ready),
      .cmd          (cmd),
      .cap_eff      (cap_eff),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_ok       (rsp_ok),
      .rsp_value    (rsp_value),
      .rsp_position (rsp_position),
      .rsp_count    (rsp_count),
      .rsp_is_empty (rsp_is_empty),
      .rsp_is_full  (rsp_is_full)
   );

endmodule
